/* rtl/core/rmie_pkg.sv */
`default_nettype none
package rmie_pkg;
  localparam int NUM_PROCS = 8;
  localparam int PID_W = 3;
  localparam int PEER_W = 4;
  localparam int ADDR_W = 32;
  localparam int ST_W = 3;
  localparam int CNT_W = 4;

  localparam logic [1:0] CMD_SEND = 2'd0;
  localparam logic [1:0] CMD_RECV = 2'd1;
  localparam logic [1:0] CMD_INT = 2'd2;

  localparam logic [PEER_W-1:0] PEER_ANY = 4'd8;
  localparam logic [PEER_W-1:0] PEER_INT = 4'd9;
  localparam logic [PEER_W-1:0] NO_TASK = 4'd10;
  localparam logic [PEER_W-1:0] LIST_END = 4'd8;

  localparam logic [ST_W-1:0] ST_COPIED = 3'd0;
  localparam logic [ST_W-1:0] ST_BLOCKED = 3'd1;
  localparam logic [ST_W-1:0] ST_INT_DELIVERED = 3'd2;
  localparam logic [ST_W-1:0] ST_INT_PENDING = 3'd3;
  localparam logic [ST_W-1:0] ST_DEADLOCK = 3'd4;
  localparam logic [ST_W-1:0] ST_INVALID = 3'd5;

  // controller -> datapath operations
  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_LOAD = 4'd1;
  localparam logic [3:0] OP_DECIDE = 4'd2;
  localparam logic [3:0] OP_CHAIN = 4'd3;
  localparam logic [3:0] OP_SEND_CHK = 4'd4;
  localparam logic [3:0] OP_APPEND = 4'd5;
  localparam logic [3:0] OP_RECV_CHK = 4'd6;
  localparam logic [3:0] OP_UNLINK = 4'd7;
  localparam logic [3:0] OP_BLOCK_RX = 4'd8;

  typedef struct packed {
    logic [3:0] op;
  } ctl_t;

  typedef struct packed {
    logic done;   // current phase finished
    logic fin;    // result is final
    logic [2:0] nxt; // next phase selector
  } sts_t;

  localparam logic [2:0] NX_CHAIN = 3'd0;
  localparam logic [2:0] NX_SEND_CHK = 3'd1;
  localparam logic [2:0] NX_APPEND = 3'd2;
  localparam logic [2:0] NX_RECV_CHK = 3'd3;
  localparam logic [2:0] NX_UNLINK = 3'd4;
  localparam logic [2:0] NX_BLOCK_RX = 3'd5;
endpackage
`default_nettype wire

/* rtl/core/rmie_if.sv */
`default_nettype none
interface rmie_req_if;
  logic valid;
  logic ready;
  logic [1:0] cmd;
  logic [rmie_pkg::PID_W-1:0] caller;
  logic [rmie_pkg::PEER_W-1:0] peer;
  logic [rmie_pkg::ADDR_W-1:0] msg_addr;
  modport source (output valid, cmd, caller, peer, msg_addr, input ready);
  modport sink (input valid, cmd, caller, peer, msg_addr, output ready);
endinterface

interface rmie_rsp_if;
  logic valid;
  logic ready;
  logic [rmie_pkg::ST_W-1:0] status;
  logic [rmie_pkg::ADDR_W-1:0] copy_dst;
  logic [rmie_pkg::ADDR_W-1:0] copy_src;
  logic woken_valid;
  logic [rmie_pkg::PID_W-1:0] woken_pid;
  modport source (output valid, status, copy_dst, copy_src, woken_valid, woken_pid,
                  input ready);
  modport sink (input valid, status, copy_dst, copy_src, woken_valid, woken_pid,
                output ready);
endinterface
`default_nettype wire

/* rtl/core/rendezvous_message_ipc_engine_unit.sv */
`default_nettype none
// channel | dir | handshake   | payload
// req     | in  | valid/ready | cmd, caller, peer, msg_addr
// rsp     | out | valid/ready | status, copy_dst, copy_src, woken_valid, woken_pid
// One item at a time: load, decide, then, where needed, a chain or queue walk
// (one entry per cycle).
// The result sits in an output register; the next item is taken only once the
// result is taken, so a held result stalls the input.
// Synchronous reset clears all per-process state and the handshake.
module rendezvous_message_ipc_engine_unit (
  input wire logic clk,
  input wire logic rst,
  rmie_req_if.sink req,
  rmie_rsp_if.source rsp
);
  rmie_pkg::ctl_t ctl;
  rmie_pkg::sts_t sts;
  logic out_load;

  rmie_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .out_load(out_load),
    .ctl(ctl), .sts(sts)
  );

  rmie_dp u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts),
    .in_cmd(req.cmd), .in_caller(req.caller), .in_peer(req.peer),
    .in_addr(req.msg_addr), .out_load(out_load),
    .status(rsp.status), .copy_dst(rsp.copy_dst), .copy_src(rsp.copy_src),
    .woken_valid(rsp.woken_valid), .woken_pid(rsp.woken_pid)
  );
endmodule
`default_nettype wire

/* rtl/core/rmie_ctrl.sv */
`default_nettype none
module rmie_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  output logic out_load,
  output rmie_pkg::ctl_t ctl,
  input  wire rmie_pkg::sts_t sts
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_CHAIN = 4'd2;
  localparam logic [3:0] S_SEND_CHK = 4'd3;
  localparam logic [3:0] S_APPEND = 4'd4;
  localparam logic [3:0] S_RECV_CHK = 4'd5;
  localparam logic [3:0] S_UNLINK = 4'd6;
  localparam logic [3:0] S_BLOCK_RX = 4'd7;
  localparam logic [3:0] S_OUT = 4'd8;

  logic [3:0] state, state_next;

  function automatic logic [3:0] phase(input logic [2:0] n);
    case (n)
      rmie_pkg::NX_CHAIN:    phase = S_CHAIN;
      rmie_pkg::NX_SEND_CHK: phase = S_SEND_CHK;
      rmie_pkg::NX_APPEND:   phase = S_APPEND;
      rmie_pkg::NX_RECV_CHK: phase = S_RECV_CHK;
      rmie_pkg::NX_UNLINK:   phase = S_UNLINK;
      default:               phase = S_BLOCK_RX;
    endcase
  endfunction

  // output register stays valid until taken; next item accepted alongside
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  // result moves into the output register when it is free
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    ctl.op = rmie_pkg::OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          ctl.op = rmie_pkg::OP_LOAD;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE:   ctl.op = rmie_pkg::OP_DECIDE;
      S_CHAIN:    ctl.op = rmie_pkg::OP_CHAIN;
      S_SEND_CHK: ctl.op = rmie_pkg::OP_SEND_CHK;
      S_APPEND:   ctl.op = rmie_pkg::OP_APPEND;
      S_RECV_CHK: ctl.op = rmie_pkg::OP_RECV_CHK;
      S_UNLINK:   ctl.op = rmie_pkg::OP_UNLINK;
      S_BLOCK_RX: ctl.op = rmie_pkg::OP_BLOCK_RX;
      S_OUT: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    if (state != S_IDLE && state != S_OUT && sts.done)
      state_next = sts.fin ? S_OUT : phase(sts.nxt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

/* rtl/core/rmie_dp.sv */
`default_nettype none
module rmie_dp (
  input  wire logic clk,
  input  wire logic rst,
  input  wire rmie_pkg::ctl_t ctl,
  output rmie_pkg::sts_t sts,
  input  wire logic [1:0] in_cmd,
  input  wire logic [rmie_pkg::PID_W-1:0] in_caller,
  input  wire logic [rmie_pkg::PEER_W-1:0] in_peer,
  input  wire logic [rmie_pkg::ADDR_W-1:0] in_addr,
  input  wire logic out_load,
  output logic [rmie_pkg::ST_W-1:0] status,
  output logic [rmie_pkg::ADDR_W-1:0] copy_dst,
  output logic [rmie_pkg::ADDR_W-1:0] copy_src,
  output logic woken_valid,
  output logic [rmie_pkg::PID_W-1:0] woken_pid
);
  localparam int N = rmie_pkg::NUM_PROCS;
  localparam int PW = rmie_pkg::PID_W;
  localparam int QW = rmie_pkg::PEER_W;
  localparam int AW = rmie_pkg::ADDR_W;

  // per-process state
  logic [N-1:0] f_send, f_recv, ipend;
  logic [PW-1:0] tgt [N];
  logic [QW-1:0] rsrc [N];
  logic [AW-1:0] pbuf [N];
  logic [QW-1:0] qhead [N];
  logic [QW-1:0] qnext [N];

  // latched request and working registers
  logic [1:0] cmd;
  logic [PW-1:0] me;
  logic [QW-1:0] peer;
  logic [AW-1:0] addr;
  logic [QW-1:0] p, prev;
  logic [rmie_pkg::CNT_W-1:0] n;

  // result being built
  logic [rmie_pkg::ST_W-1:0] r_st;
  logic [AW-1:0] r_dst, r_src;
  logic r_wv;
  logic [PW-1:0] r_wp;

  logic peer_pid, p_pid;
  logic [PW-1:0] pi, peer_i;
  assign peer_pid = peer < QW'(N);
  assign p_pid = p < QW'(N);
  assign pi = p[PW-1:0];
  assign peer_i = peer[PW-1:0];

  logic nend;
  assign nend = n == rmie_pkg::CNT_W'(N);

  always_comb begin
    sts = '0;
    case (ctl.op)
      rmie_pkg::OP_DECIDE: begin
        sts.done = 1'b1;
        if (cmd == rmie_pkg::CMD_INT || cmd > 2'd2 || f_send[me] || f_recv[me]
            || peer == {1'b0, me}) sts.fin = 1'b1;
        else if (cmd == rmie_pkg::CMD_SEND) begin
          if (!peer_pid) sts.fin = 1'b1;
          else sts.nxt = rmie_pkg::NX_CHAIN;
        end else begin
          if (!(peer_pid || peer == rmie_pkg::PEER_ANY || peer == rmie_pkg::PEER_INT))
            sts.fin = 1'b1;
          else if (ipend[me] && (peer == rmie_pkg::PEER_ANY || peer == rmie_pkg::PEER_INT))
            sts.fin = 1'b1;
          else sts.nxt = rmie_pkg::NX_RECV_CHK;
        end
      end
      rmie_pkg::OP_CHAIN: begin
        sts.done = 1'b1;
        if (nend || !p_pid || !f_send[pi]) sts.nxt = rmie_pkg::NX_SEND_CHK;
        else if (tgt[pi] == me) sts.fin = 1'b1;
        else sts.done = 1'b0;
      end
      rmie_pkg::OP_SEND_CHK: begin
        sts.done = 1'b1;
        if (f_recv[peer_i] && (rsrc[peer_i] == rmie_pkg::PEER_ANY || rsrc[peer_i] == {1'b0, me}))
          sts.fin = 1'b1;
        else sts.nxt = rmie_pkg::NX_APPEND;
      end
      rmie_pkg::OP_APPEND: begin
        sts.done = !p_pid || nend || !(qnext[pi] < QW'(N));
        sts.fin = 1'b1;
      end
      rmie_pkg::OP_RECV_CHK: begin
        sts.done = 1'b1;
        if (peer == rmie_pkg::PEER_ANY) begin
          sts.nxt = (qhead[me] < QW'(N)) ? rmie_pkg::NX_UNLINK : rmie_pkg::NX_BLOCK_RX;
        end else if (peer_pid && f_send[peer_i] && tgt[peer_i] == me)
          sts.nxt = rmie_pkg::NX_UNLINK;
        else sts.nxt = rmie_pkg::NX_BLOCK_RX;
      end
      rmie_pkg::OP_UNLINK: begin
        sts.done = 1'b1;
        if (nend || !p_pid) sts.nxt = rmie_pkg::NX_BLOCK_RX;
        else if (p == peer) sts.fin = 1'b1;
        else sts.done = 1'b0;
      end
      rmie_pkg::OP_BLOCK_RX: begin
        sts.done = 1'b1;
        sts.fin = 1'b1;
      end
      default: sts = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_send <= '0;
      f_recv <= '0;
      ipend <= '0;
      for (int i = 0; i < N; i++) begin
        tgt[i] <= '0;
        rsrc[i] <= rmie_pkg::NO_TASK;
        pbuf[i] <= '0;
        qhead[i] <= rmie_pkg::LIST_END;
        qnext[i] <= rmie_pkg::LIST_END;
      end
    end else begin
      case (ctl.op)
        rmie_pkg::OP_LOAD: begin
          cmd <= in_cmd; me <= in_caller; peer <= in_peer; addr <= in_addr;
          r_st <= rmie_pkg::ST_INVALID; r_dst <= '0; r_src <= '0;
          r_wv <= 1'b0; r_wp <= '0;
        end
        rmie_pkg::OP_DECIDE: begin
          n <= '0;
          p <= peer;
          if (cmd == rmie_pkg::CMD_INT) begin
            if (f_recv[me] && (rsrc[me] == rmie_pkg::PEER_INT || rsrc[me] == rmie_pkg::PEER_ANY))
            begin
              r_st <= rmie_pkg::ST_INT_DELIVERED; r_dst <= pbuf[me];
              r_wv <= 1'b1; r_wp <= me;
              pbuf[me] <= '0; ipend[me] <= 1'b0; f_recv[me] <= 1'b0;
              rsrc[me] <= rmie_pkg::NO_TASK;
            end else begin
              ipend[me] <= 1'b1;
              r_st <= rmie_pkg::ST_INT_PENDING;
            end
          end else if (cmd == rmie_pkg::CMD_RECV && !f_send[me] && !f_recv[me]
                       && peer != {1'b0, me} && ipend[me]
                       && (peer == rmie_pkg::PEER_ANY || peer == rmie_pkg::PEER_INT)) begin
            ipend[me] <= 1'b0;
            r_st <= rmie_pkg::ST_INT_DELIVERED; r_dst <= addr;
          end
        end
        rmie_pkg::OP_CHAIN: begin
          if (!nend && p_pid && f_send[pi]) begin
            if (tgt[pi] == me) r_st <= rmie_pkg::ST_DEADLOCK;
            p <= {1'b0, tgt[pi]};
            n <= n + 1'b1;
          end
        end
        rmie_pkg::OP_SEND_CHK: begin
          n <= '0;
          p <= qhead[peer_i];
          if (f_recv[peer_i] && (rsrc[peer_i] == rmie_pkg::PEER_ANY
              || rsrc[peer_i] == {1'b0, me})) begin
            r_st <= rmie_pkg::ST_COPIED; r_dst <= pbuf[peer_i]; r_src <= addr;
            r_wv <= 1'b1; r_wp <= peer_i;
            pbuf[peer_i] <= '0; f_recv[peer_i] <= 1'b0;
            rsrc[peer_i] <= rmie_pkg::NO_TASK;
          end else begin
            f_send[me] <= 1'b1; tgt[me] <= peer_i; pbuf[me] <= addr;
            qnext[me] <= rmie_pkg::LIST_END;
            r_st <= rmie_pkg::ST_BLOCKED;
          end
        end
        rmie_pkg::OP_APPEND: begin
          // walk to the tail, then link the caller
          if (!p_pid) qhead[peer_i] <= {1'b0, me};
          else if (nend || !(qnext[pi] < QW'(N))) qnext[pi] <= {1'b0, me};
          else begin
            p <= qnext[pi];
            n <= n + 1'b1;
          end
        end
        rmie_pkg::OP_RECV_CHK: begin
          n <= '0;
          prev <= rmie_pkg::LIST_END;
          p <= qhead[me];
          if (peer == rmie_pkg::PEER_ANY) peer <= qhead[me];
        end
        rmie_pkg::OP_UNLINK: begin
          if (!nend && p_pid) begin
            if (p == peer) begin
              if (prev < QW'(N)) qnext[prev[PW-1:0]] <= qnext[pi];
              else qhead[me] <= qnext[pi];
              qnext[pi] <= rmie_pkg::LIST_END;
              r_st <= rmie_pkg::ST_COPIED; r_dst <= addr; r_src <= pbuf[pi];
              r_wv <= 1'b1; r_wp <= pi;
              pbuf[pi] <= '0; f_send[pi] <= 1'b0; tgt[pi] <= '0;
            end else begin
              prev <= p;
              p <= qnext[pi];
              n <= n + 1'b1;
            end
          end
        end
        rmie_pkg::OP_BLOCK_RX: begin
          f_recv[me] <= 1'b1; pbuf[me] <= addr; rsrc[me] <= peer;
          r_st <= rmie_pkg::ST_BLOCKED;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      status <= r_st; copy_dst <= r_dst; copy_src <= r_src;
      woken_valid <= r_wv; woken_pid <= r_wp;
    end
  end
endmodule
`default_nettype wire

/* verif/rmie_tb_pkg.sv */
package rmie_tb_pkg;
  import rmie_pkg::*;

  // one request item
  typedef struct {
    logic [1:0] cmd;
    logic [PID_W-1:0] caller;
    logic [PEER_W-1:0] peer;
    logic [ADDR_W-1:0] msg_addr;
  } ipc_req_t;

  // one response item
  typedef struct {
    logic [ST_W-1:0] status;
    logic [ADDR_W-1:0] copy_dst;
    logic [ADDR_W-1:0] copy_src;
    logic woken_valid;
    logic [PID_W-1:0] woken_pid;
  } ipc_rsp_t;
endpackage

/* verif/rmie_tb_if.sv */
// interfaces come from the RTL (rmie_req_if, rmie_rsp_if); this file holds
// the bus-idle helper shared by the stimulus side
package rmie_tb_idle_pkg;
  // idle with a chance of 7 in a hundred unless quiet
  function automatic bit idle_now(bit quiet);
    return !quiet && ($urandom_range(99) < 7);
  endfunction
endpackage

/* verif/rmie_ipc_checker.sv */
module rmie_ipc_checker (
  input logic clk,
  input logic rst,
  rmie_req_if req,
  rmie_rsp_if rsp,
  output int fail_count,
  output int pending_count,
  output int accept_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import rmie_pkg::*;
  import rmie_tb_pkg::*;

  localparam logic [1:0] F_SEND = 2'b01;
  localparam logic [1:0] F_RECV = 2'b10;

  // shadow of the per-process state
  logic [1:0] wflags [NUM_PROCS];
  logic [PID_W-1:0] tgt [NUM_PROCS];
  logic [PEER_W-1:0] src_wait [NUM_PROCS];
  logic [ADDR_W-1:0] buf_addr [NUM_PROCS];
  logic irq_pend [NUM_PROCS];
  logic [PEER_W-1:0] qhead [NUM_PROCS];
  logic [PEER_W-1:0] qnext [NUM_PROCS];

  ipc_rsp_t expected_rsp_q[$];
  int status_seen [6];

  function automatic bit is_pid(logic [PEER_W-1:0] v);
    return v < NUM_PROCS;
  endfunction

  function automatic void clear_state();
    for (int i = 0; i < NUM_PROCS; i++) begin
      wflags[i] = '0; tgt[i] = '0; src_wait[i] = NO_TASK; buf_addr[i] = '0;
      irq_pend[i] = 1'b0; qhead[i] = LIST_END; qnext[i] = LIST_END;
    end
  endfunction

  // walk blocked senders from 'from'; true if it comes back to 'me'
  function automatic bit cycle_to(logic [PEER_W-1:0] from, logic [PEER_W-1:0] me);
    logic [PEER_W-1:0] p;
    p = from;
    for (int n = 0; n < NUM_PROCS; n++) begin
      if (!is_pid(p) || !wflags[p][0]) return 1'b0;
      if (tgt[p] == me) return 1'b1;
      p = tgt[p];
    end
    return 1'b0;
  endfunction

  function automatic void enqueue_sender(int dest, int s);
    logic [PEER_W-1:0] p;
    p = qhead[dest];
    qnext[s] = LIST_END;
    if (!is_pid(p)) begin
      qhead[dest] = s;
      return;
    end
    for (int n = 0; n < NUM_PROCS; n++) begin
      if (!is_pid(qnext[p])) break;
      p = qnext[p];
    end
    qnext[p] = s;
  endfunction

  function automatic bit dequeue_sender(int owner, int s);
    logic [PEER_W-1:0] p, prev;
    p = qhead[owner];
    prev = LIST_END;
    for (int n = 0; n < NUM_PROCS && is_pid(p); n++) begin
      if (p == s) begin
        if (is_pid(prev)) qnext[prev] = qnext[p];
        else qhead[owner] = qnext[p];
        qnext[p] = LIST_END;
        return 1'b1;
      end
      prev = p;
      p = qnext[p];
    end
    return 1'b0;
  endfunction

  function automatic ipc_rsp_t mk(logic [ST_W-1:0] st, logic [ADDR_W-1:0] d,
                                  logic [ADDR_W-1:0] s, logic wv, logic [PID_W-1:0] wp);
    ipc_rsp_t r;
    r.status = st; r.copy_dst = d; r.copy_src = s; r.woken_valid = wv; r.woken_pid = wp;
    return r;
  endfunction

  // rendezvous decision for one request, updates shadow state
  function automatic ipc_rsp_t rendezvous(ipc_req_t q);
    int me, pr, from;
    logic [ADDR_W-1:0] d;
    bit got;
    me = q.caller;
    pr = q.peer;
    if (q.cmd != CMD_SEND && q.cmd != CMD_RECV && q.cmd != CMD_INT)
      return mk(ST_INVALID, 0, 0, 0, 0);
    if (q.cmd == CMD_INT) begin
      if (wflags[me][1] && (src_wait[me] == PEER_INT || src_wait[me] == PEER_ANY)) begin
        d = buf_addr[me];
        buf_addr[me] = '0; irq_pend[me] = 1'b0;
        wflags[me] &= ~F_RECV; src_wait[me] = NO_TASK;
        return mk(ST_INT_DELIVERED, d, 0, 1, me);
      end
      irq_pend[me] = 1'b1;
      return mk(ST_INT_PENDING, 0, 0, 0, 0);
    end
    if (wflags[me] != 0 || pr == me) return mk(ST_INVALID, 0, 0, 0, 0);
    if (q.cmd == CMD_SEND) begin
      if (!is_pid(pr)) return mk(ST_INVALID, 0, 0, 0, 0);
      if (cycle_to(pr, me)) return mk(ST_DEADLOCK, 0, 0, 0, 0);
      if (wflags[pr][1] && (src_wait[pr] == PEER_ANY || src_wait[pr] == me)) begin
        d = buf_addr[pr];
        buf_addr[pr] = '0; wflags[pr] &= ~F_RECV; src_wait[pr] = NO_TASK;
        return mk(ST_COPIED, d, q.msg_addr, 1, pr);
      end
      wflags[me] |= F_SEND; tgt[me] = pr; buf_addr[me] = q.msg_addr;
      enqueue_sender(pr, me);
      return mk(ST_BLOCKED, 0, 0, 0, 0);
    end
    // receive
    if (!(is_pid(pr) || pr == PEER_ANY || pr == PEER_INT))
      return mk(ST_INVALID, 0, 0, 0, 0);
    if (irq_pend[me] && (pr == PEER_ANY || pr == PEER_INT)) begin
      irq_pend[me] = 1'b0;
      return mk(ST_INT_DELIVERED, q.msg_addr, 0, 0, 0);
    end
    got = 1'b0;
    from = LIST_END;
    if (pr == PEER_ANY) begin
      from = qhead[me];
      if (is_pid(from)) got = dequeue_sender(me, from);
    end else if (is_pid(pr)) begin
      from = pr;
      if (wflags[from][0] && tgt[from] == me) got = dequeue_sender(me, from);
    end
    if (got) begin
      d = buf_addr[from];
      buf_addr[from] = '0; wflags[from] &= ~F_SEND; tgt[from] = '0;
      return mk(ST_COPIED, q.msg_addr, d, 1, from);
    end
    wflags[me] |= F_RECV; buf_addr[me] = q.msg_addr; src_wait[me] = pr;
    return mk(ST_BLOCKED, 0, 0, 0, 0);
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  assign pending_count = expected_rsp_q.size();

  always @(posedge clk) begin
    ipc_req_t r;
    ipc_rsp_t e;
    if (rst) begin
      clear_state();
      expected_rsp_q.delete();
    end else begin
      if (req.valid && req.ready) begin
        r.cmd = req.cmd; r.caller = req.caller; r.peer = req.peer; r.msg_addr = req.msg_addr;
        expected_rsp_q.push_back(rendezvous(r));
        accept_count++;
      end
      if (rsp.valid && rsp.ready) begin
        accept_count++;
        if (expected_rsp_q.size() == 0) begin
          report("unexpected response", rsp.status, 0);
        end else begin
          e = expected_rsp_q.pop_front();
          if (e.status < 6) status_seen[e.status]++;
          if (rsp.status !== e.status) report("status", rsp.status, e.status);
          if (rsp.copy_dst !== e.copy_dst) report("copy_dst", rsp.copy_dst, e.copy_dst);
          if (rsp.copy_src !== e.copy_src) report("copy_src", rsp.copy_src, e.copy_src);
          if (rsp.woken_valid !== e.woken_valid)
            report("woken_valid", rsp.woken_valid, e.woken_valid);
          if (rsp.woken_pid !== e.woken_pid) report("woken_pid", rsp.woken_pid, e.woken_pid);
        end
      end
    end
  end

  initial begin
    fail_count = 0;
    accept_count = 0;
    for (int i = 0; i < 6; i++) status_seen[i] = 0;
  end

  function automatic void print_coverage();
    $display("responses by status copied/blocked/int_deliv/int_pend/deadlock/invalid:"
             , " %0d/%0d/%0d/%0d/%0d/%0d", status_seen[0], status_seen[1],
             status_seen[2], status_seen[3], status_seen[4], status_seen[5]);
  endfunction
endmodule

/* verif/rendezvous_message_ipc_engine_unit_tb.sv */
module rendezvous_message_ipc_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rmie_pkg::*;
  import rmie_tb_idle_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 1950;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic quiet = 1'b0;
  logic done = 1'b0;
  int fail_count, pending_count, accept_count;
  int item_count = 0;

  rmie_req_if req ();
  rmie_rsp_if rsp ();

  rendezvous_message_ipc_engine_unit u_dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));
  rmie_ipc_checker u_chk (.clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .fail_count(fail_count), .pending_count(pending_count), .accept_count(accept_count));

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // response back-pressure
  initial rsp.ready = 1'b0;
  always @(negedge clk) begin
    rsp.ready <= rst ? 1'b0 : !idle_now(quiet);
  end

  // send one item, with random gaps before it; valid stays up for the next
  task automatic send_item(logic [1:0] c, logic [PID_W-1:0] who,
                           logic [PEER_W-1:0] p, logic [ADDR_W-1:0] a);
    while (idle_now(quiet)) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.cmd <= c; req.caller <= who; req.peer <= p; req.msg_addr <= a;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    item_count++;
    @(negedge clk);
  endtask

  function automatic logic [ADDR_W-1:0] rand_addr();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // mostly sends and receives among all NUM_PROCS processes, plus interrupts and random commands
  task automatic random_item();
    logic [PID_W-1:0] a;
    logic [PEER_W-1:0] p;
    int k;
    k = $urandom_range(99);
    a = $urandom_range(NUM_PROCS - 1);
    if (k < 40) begin
      p = $urandom_range(NUM_PROCS - 1);
      send_item(CMD_SEND, a, p, rand_addr());
    end else if (k < 80) begin
      p = ($urandom_range(3) == 0) ? PEER_ANY : $urandom_range(NUM_PROCS - 1);
      send_item(CMD_RECV, a, p, rand_addr());
    end else if (k < 88) begin
      send_item(CMD_RECV, a, PEER_INT, rand_addr());
    end else if (k < 94) begin
      send_item(CMD_INT, a, $urandom_range(15), rand_addr());
    end else begin
      send_item($urandom_range(3), a, $urandom_range(15), rand_addr());
    end
  endtask

  // watchdog on cycles with no handshake
  initial begin
    int last, idle;
    last = 0;
    idle = 0;
    forever begin
      @(posedge clk);
      if (accept_count != last || rst) begin
        last = accept_count;
        idle = 0;
      end else if (++idle >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", idle);
        $display("rendezvous_message_ipc_engine_unit_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    req.valid = 1'b0;
    req.cmd = CMD_SEND; req.caller = '0; req.peer = '0; req.msg_addr = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: rendezvous, queues, unlink, interrupts, deadlock, invalids
    quiet <= 1'b1;
    send_item(CMD_SEND, 3'd1, 4'd2, 32'hFFFF_FFFF);   // blocks
    send_item(CMD_SEND, 3'd3, 4'd2, 32'h0000_0000);   // queued behind 1
    send_item(CMD_SEND, 3'd4, 4'd2, 32'hA5A5_5A5A);   // queued behind 3
    send_item(CMD_RECV, 3'd2, 4'd3, 32'h1234_5678);   // unlink from middle
    send_item(CMD_RECV, 3'd2, PEER_ANY, 32'h0);       // head
    send_item(CMD_SEND, 3'd2, 4'd4, 32'h5);           // 4 sends to 2: deadlock
    send_item(CMD_RECV, 3'd2, PEER_ANY, 32'h7);
    send_item(CMD_RECV, 3'd5, 4'd6, 32'hDEAD_BEEF);   // blocks
    send_item(CMD_SEND, 3'd6, 4'd5, 32'hCAFE_F00D);   // copy, wakes 5
    send_item(CMD_RECV, 3'd7, PEER_INT, 32'h11);      // waits for irq
    send_item(CMD_INT, 3'd7, 4'd15, 32'hFFFF_FFFF);   // delivered
    send_item(CMD_INT, 3'd0, 4'd0, 32'h0);            // pending
    send_item(CMD_RECV, 3'd0, PEER_ANY, 32'h22);      // takes pending irq
    send_item(2'd3, 3'd0, 4'd1, 32'h0);               // unknown command
    send_item(CMD_SEND, 3'd0, 4'd0, 32'h0);           // send to self
    send_item(CMD_SEND, 3'd0, PEER_ANY, 32'h0);
    send_item(CMD_SEND, 3'd0, PEER_INT, 32'h0);
    send_item(CMD_RECV, 3'd0, 4'd15, 32'h0);          // peer out of range
    send_item(CMD_RECV, 3'd1, 4'd1, 32'h0);           // receive from self
    send_item(CMD_RECV, 3'd0, 4'd1, 32'h0);           // blocks
    send_item(CMD_SEND, 3'd0, 4'd1, 32'h0);           // busy caller
    send_item(CMD_SEND, 3'd1, 4'd0, 32'h3C3C_3C3C);   // copy
    // hold off until every response is back
    req.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet <= (i >= 600 && i < 900);
      random_item();
    end
    quiet <= 1'b0;
    req.valid <= 1'b0;

    while (pending_count != 0) @(negedge clk);
    repeat (40) @(posedge clk);
    u_chk.print_coverage();
    $display("%0d request items driven, random traffic among %0d processes",
             item_count, NUM_PROCS);
    if (fail_count == 0) begin
      $display("rendezvous_message_ipc_engine_unit_tb: clean");
    end else begin
      $display("rendezvous_message_ipc_engine_unit_tb: errors");
    end
    $finish;
  end
endmodule
